>>> sv/smc_pkg.sv
// Shared types, constants and character tables for the SIP method classifier.
package smc_pkg;

   localparam int NUM_METHODS = 11;
   localparam int MAX_PREFIX_LEN = 12;
   localparam int SSDP_LEN = 17;

   localparam logic [7:0] MIN_LENGTH_RESET = 8'd64;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   localparam logic [31:0] KEY_A = 32'h4941_5449;
   localparam logic [31:0] KEY_B = 32'h5349_4220;
   localparam logic [32:0] MAGIC_ADD_LO = 33'h0_7efe_feff;
   localparam logic [31:0] MAGIC_ADD_HI = 32'h7efe_fefe;
   localparam logic [31:0] MAGIC_MASK_LO = 32'h8101_0100;
   localparam logic [31:0] MAGIC_MASK_HI = 32'h8101_0101;

   typedef enum logic [2:0] {
      VERDICT_SIP       = 3'd0,
      VERDICT_TOO_SHORT = 3'd1,
      VERDICT_QUICK_OUT = 3'd2,
      VERDICT_NO_PREFIX = 3'd3,
      VERDICT_SSDP      = 3'd4
   } verdict_type;

   localparam logic [3:0] METHOD_NONE = 4'd0;
   localparam logic [3:0] METHOD_NOTIFY = 4'd5;

   localparam logic [8*MAX_PREFIX_LEN-1:0] METHOD_TEXT [NUM_METHODS] = '{
      "REGISTER", "INVITE", "OPTIONS :sip", "CANCEL", "INFO", "NOTIFY",
      "REPLY", "ACK", "BYE", "SUBSCRIBE", "PUBLISH"
   };

   localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
      4'd8, 4'd6, 4'd12, 4'd6, 4'd4, 4'd6, 4'd5, 4'd3, 4'd3, 4'd9, 4'd7
   };

   localparam logic [8*SSDP_LEN-1:0] SSDP_TEXT = "NOTIFY * HTTP/1.1";

   typedef struct packed {
      logic [7:0]             count;
      logic [31:0]            word;
      logic [NUM_METHODS-1:0] alive;
      logic                   ssdp;
   } smc_view_type;

   typedef struct packed {
      logic        is_sip;
      logic [3:0]  method_code;
      verdict_type verdict;
   } smc_result_type;

   function automatic logic [7:0] method_char(input logic [3:0] idx, input logic [3:0] pos);
      logic [3:0] sh;
      sh = METHOD_LEN[idx] - 4'd1 - pos;
      return METHOD_TEXT[idx][8*sh +: 8];
   endfunction

   function automatic logic [7:0] ssdp_char(input logic [4:0] pos);
      logic [4:0] sh;
      sh = 5'(SSDP_LEN - 1) - pos;
      return SSDP_TEXT[8*sh +: 8];
   endfunction

   // Split-add quick test: low half add feeds the high half by its carry.
   function automatic logic quick_hit(input logic [31:0] w, input logic [31:0] key);
      logic [31:0] m;
      logic [32:0] lo;
      logic [31:0] hi;
      m = w ^ key;
      lo = {1'b0, m} + MAGIC_ADD_LO;
      hi = MAGIC_ADD_HI + {31'd0, lo[32]};
      return ((hi & MAGIC_MASK_HI) != 32'd0) ||
             (((lo[31:0] ^ ~m) & MAGIC_MASK_LO) != 32'd0);
   endfunction

endpackage

>>> sv/sip_method_classifier.sv
// Top level of the SIP method classifier: input register, tracking, verdict, result register.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, payload_byte, last_byte | in, one beat per payload byte
//   rsp     | rsp_valid/ready, is_sip, method_code,    | out, one beat per payload
//           | verdict                                 |
//   csr     | csr_write_enable, csr_write_data        | in, minimum payload length
//
// One byte is accepted every cycle; the verdict for a last byte is formed while the byte sits in the
// input register and is loaded into the result register when that byte advances.
// Only a last byte whose result register is still occupied stalls the input.
// Synchronous reset clears the byte count, first word and both valid bits, sets the match flags
// and sets the minimum length to 64.
module sip_method_classifier
   import smc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_payload_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_sip,
   output logic [3:0] rsp_method_code,
   output logic [2:0] rsp_verdict,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           out_valid_ff;
   smc_result_type out_ff;
   logic [7:0]     min_length_ff;

   logic           advance;
   smc_view_type   view;
   smc_result_type result;

   assign advance = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   smc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_value (in_byte_ff),
      .last_beat  (in_last_ff),
      .view       (view)
   );

   smc_decide u_decide (
      .view       (view),
      .min_length (min_length_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         min_length_ff <= MIN_LENGTH_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            min_length_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_payload_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_is_sip = out_ff.is_sip;
   assign rsp_method_code = out_ff.method_code;
   assign rsp_verdict = out_ff.verdict;

endmodule

>>> sv/smc_track.sv
// Per-payload tracking state: byte count, first word and prefix match flags.
module smc_track
   import smc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic [7:0]   byte_value,
   input  logic         last_beat,
   output smc_view_type view
);

   logic [7:0]             count_ff;
   logic [31:0]            word_ff;
   logic [NUM_METHODS-1:0] alive_ff;
   logic                   ssdp_ff;

   logic [7:0]             count_in;
   logic [31:0]            word_in;
   logic [NUM_METHODS-1:0] alive_in;
   logic                   ssdp_in;

   always_comb begin
      view.count = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 8'd1;
      view.word = word_ff;
      if (count_ff < 8'd4) begin
         case (count_ff[1:0])
            2'd0:    view.word = word_ff | {byte_value, 24'd0};
            2'd1:    view.word = word_ff | {8'd0, byte_value, 16'd0};
            2'd2:    view.word = word_ff | {16'd0, byte_value, 8'd0};
            default: view.word = word_ff | {24'd0, byte_value};
         endcase
      end
      for (int i = 0; i < NUM_METHODS; i++) begin
         view.alive[i] = alive_ff[i] &
            !((count_ff < {4'd0, METHOD_LEN[i]}) &&
              (method_char(4'(i), count_ff[3:0]) != byte_value));
      end
      view.ssdp = ssdp_ff &
         !((count_ff < 8'(SSDP_LEN)) && (ssdp_char(count_ff[4:0]) != byte_value));
   end

   always_comb begin
      count_in = count_ff;
      word_in = word_ff;
      alive_in = alive_ff;
      ssdp_in = ssdp_ff;
      if (advance) begin
         if (last_beat) begin
            count_in = 8'd0;
            word_in = 32'd0;
            alive_in = '1;
            ssdp_in = 1'b1;
         end else begin
            count_in = view.count;
            word_in = view.word;
            alive_in = view.alive;
            ssdp_in = view.ssdp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
         word_ff <= 32'd0;
         alive_ff <= '1;
         ssdp_ff <= 1'b1;
      end else begin
         count_ff <= count_in;
         word_ff <= word_in;
         alive_ff <= alive_in;
         ssdp_ff <= ssdp_in;
      end
   end

endmodule

>>> sv/smc_decide.sv
// Verdict logic applied to the payload state as it stands after the last byte.
module smc_decide
   import smc_pkg::*;
(
   input  smc_view_type   view,
   input  logic [7:0]     min_length,
   output smc_result_type result
);

   logic       found;
   logic [3:0] code;

   always_comb begin
      found = 1'b0;
      code = METHOD_NONE;
      for (int i = NUM_METHODS - 1; i >= 0; i--) begin
         if (view.alive[i] && (view.count >= {4'd0, METHOD_LEN[i]})) begin
            found = 1'b1;
            code = 4'(i);
         end
      end
   end

   always_comb begin
      result.is_sip = 1'b0;
      result.method_code = METHOD_NONE;
      if (view.count < min_length) begin
         result.verdict = VERDICT_TOO_SHORT;
      end else if (!quick_hit(view.word, KEY_A) && !quick_hit(view.word, KEY_B)) begin
         result.verdict = VERDICT_QUICK_OUT;
      end else if (!found) begin
         result.verdict = VERDICT_NO_PREFIX;
      end else if (code == METHOD_NOTIFY && view.ssdp && view.count >= 8'(SSDP_LEN)) begin
         result.verdict = VERDICT_SSDP;
      end else begin
         result.verdict = VERDICT_SIP;
         result.is_sip = 1'b1;
         result.method_code = code;
      end
   end

endmodule

>>> sv/smc_checker.sv
// Port-level checks for the SIP method classifier, bound to the top level.
module smc_checker
   import smc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_sip,
   input logic [3:0] rsp_method_code,
   input logic [2:0] rsp_verdict
);

   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("Result beat shown right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_sip) &&
         $stable(rsp_method_code) && $stable(rsp_verdict))
      else $error("Stalled result beat changed or vanished.");

   a_sip_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_sip == (rsp_verdict == VERDICT_SIP))
      else $error("SIP flag disagrees with the verdict.");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_sip |-> rsp_method_code == METHOD_NONE)
      else $error("Method code set on a payload that is not SIP.");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_method_code < 4'(NUM_METHODS) && rsp_verdict <= VERDICT_SSDP)
      else $error("Method code or verdict out of range.");

endmodule

bind sip_method_classifier smc_checker u_smc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_is_sip      (rsp_is_sip),
   .rsp_method_code (rsp_method_code),
   .rsp_verdict     (rsp_verdict)
);
